>>> sv/cut_list_merge_time_remap_top_macros.svh
// assertion helpers shared by the span table logic
`ifndef CUT_LIST_MERGE_TIME_REMAP_TOP_MACROS_SVH
`define CUT_LIST_MERGE_TIME_REMAP_TOP_MACROS_SVH

// plain clocked property, masked while reset is high
`define CLMTR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define CLMTR_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error(msg);

`endif

>>> sv/clmtr_pkg.sv
package clmtr_pkg;

   localparam int MAX_SPANS = 64;
   localparam int TIME_W    = 48;
   localparam int IDX_W     = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
   localparam int CNT_W     = $clog2(MAX_SPANS + 1);

   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_SPANS);
   localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

   localparam logic [1:0] ACTION_CLEAR = 2'd0;
   localparam logic [1:0] ACTION_ADD   = 2'd1;
   localparam logic [1:0] ACTION_MAP   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_ORDER = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   typedef struct packed {
      logic signed [TIME_W-1:0] span_start;
      logic signed [TIME_W-1:0] span_end;
   } span_word_type;

   typedef struct packed {
      logic          wr_en;
      logic [IDX_W-1:0] wr_addr;
      span_word_type wr_data;
      logic          rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

endpackage

>>> sv/clmtr_chan_if.sv
interface clmtr_req_if import clmtr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               action;
   logic signed [TIME_W-1:0] span_start;
   logic signed [TIME_W-1:0] span_end;
   logic signed [TIME_W-1:0] query_time;

   modport source (output valid, action, span_start, span_end, query_time, input ready);
   modport sink (input valid, action, span_start, span_end, query_time, output ready);
endinterface

interface clmtr_rsp_if import clmtr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TIME_W-1:0] mapped_time;
   logic [1:0]               status;
   logic [CNT_W-1:0]         entry_count;

   modport source (output valid, mapped_time, status, entry_count, input ready);
   modport sink (input valid, mapped_time, status, entry_count, output ready);
endinterface

>>> sv/cut_list_merge_time_remap_top.sv
// excluded-span table with merge on insert and source-to-output time remap
// req_chan carries one transaction per command: action selects clear, add
// span [span_start, span_end) or map query_time; spans must come sorted by start
// rsp_chan returns exactly one transaction per command: mapped_time (zero
// unless mapping), status and the number of merged spans now held
// clear, add and unused codes: the command passes to ST_FIN, where the result is
// loaded once the output register is free; no new command is taken until then
// map: the span memory is read one entry per cycle until the query falls
// before an entry's end; visiting k entries (1 to 64), the walk goes through
// ST_WALK, ST_SUM and ST_FIN; the next command waits until the result is loaded
// map on an empty table behaves like an add for timing
// the walk is bound by the single read port of the span memory
// reset empties the table and sets the last accepted start to the most
// negative time; no memory sweep is needed as entries above the count are
// never read
// a stalled receiver holds the result in the output register; one further
// command is accepted and completes internally, then req_chan.ready stays low
module cut_list_merge_time_remap_top import clmtr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   clmtr_req_if.sink    req_chan,
   clmtr_rsp_if.source  rsp_chan
);

   ram_req_type   ram_req;
   span_word_type rd_data;

   clmtr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .ram_req  (ram_req),
      .rd_data  (rd_data)
   );

   clmtr_span_ram u_span_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

>>> sv/clmtr_span_ram.sv
module clmtr_span_ram import clmtr_pkg::*; (
   input  logic          clock,
   input  ram_req_type   ram_req,
   output span_word_type rd_data
);

   span_word_type mem_ff [MAX_SPANS];
   span_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/clmtr_ctrl.sv
`include "cut_list_merge_time_remap_top_macros.svh"

module clmtr_ctrl import clmtr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   clmtr_req_if.sink          req_chan,
   clmtr_rsp_if.source        rsp_chan,
   output ram_req_type        ram_req,
   input  span_word_type      rd_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [TIME_W-1:0] last_acc_ff, last_acc_in;
   logic signed [TIME_W-1:0] last_start_ff, last_start_in;
   logic signed [TIME_W-1:0] last_end_ff, last_end_in;
   logic signed [TIME_W-1:0] query_ff, query_in;
   logic [TIME_W-1:0]        end_sum_ff, end_sum_in;
   logic [TIME_W-1:0]        start_sum_ff, start_sum_in;
   logic [IDX_W-1:0]         walk_idx_ff, walk_idx_in;
   logic [TIME_W-1:0]        res_mapped_ff, res_mapped_in;
   logic [1:0]               res_status_ff, res_status_in;
   logic                     out_valid_ff, out_valid_in;
   logic [TIME_W-1:0]        out_mapped_ff, out_mapped_in;
   logic [1:0]               out_status_ff, out_status_in;
   logic [CNT_W-1:0]         out_count_ff, out_count_in;

   logic accept;
   logic slot_free;
   logic more_entries;
   logic signed [TIME_W-1:0] req_start;
   logic signed [TIME_W-1:0] req_end;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign slot_free      = !out_valid_ff || rsp_chan.ready;
   assign req_start      = req_chan.span_start;
   assign req_end        = req_chan.span_end;
   assign more_entries   = (CNT_W'(walk_idx_ff) + CNT_W'(1)) < count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_acc_in   = last_acc_ff;
      last_start_in = last_start_ff;
      last_end_in   = last_end_ff;
      query_in      = query_ff;
      end_sum_in    = end_sum_ff;
      start_sum_in  = start_sum_ff;
      walk_idx_in   = walk_idx_ff;
      res_mapped_in = res_mapped_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_mapped_in = out_mapped_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      ram_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_mapped_in = '0;
               res_status_in = STATUS_OK;
               state_in      = ST_FIN;
               case (req_chan.action)
                  ACTION_CLEAR: begin
                     count_in    = '0;
                     last_acc_in = TIME_MIN;
                  end
                  ACTION_ADD: begin
                     if (req_end <= req_start) begin
                        res_status_in = STATUS_EMPTY;
                     end else if (req_start < last_acc_ff) begin
                        res_status_in = STATUS_ORDER;
                     end else if (count_ff != '0 && req_start <= last_end_ff) begin
                        // overlap or touch: widen the last entry in place
                        ram_req.wr_en              = 1'b1;
                        ram_req.wr_addr            = IDX_W'(count_ff - CNT_W'(1));
                        ram_req.wr_data.span_start = last_start_ff;
                        ram_req.wr_data.span_end   = (req_end > last_end_ff) ?
                                                     req_end : last_end_ff;
                        last_end_in                = ram_req.wr_data.span_end;
                        last_acc_in                = req_start;
                     end else if (count_ff >= COUNT_MAX) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        ram_req.wr_en              = 1'b1;
                        ram_req.wr_addr            = IDX_W'(count_ff);
                        ram_req.wr_data.span_start = req_start;
                        ram_req.wr_data.span_end   = req_end;
                        count_in                   = count_ff + CNT_W'(1);
                        last_start_in              = req_start;
                        last_end_in                = req_end;
                        last_acc_in                = req_start;
                     end
                  end
                  ACTION_MAP: begin
                     query_in     = req_chan.query_time;
                     end_sum_in   = '0;
                     start_sum_in = '0;
                     if (count_ff == '0) begin
                        res_mapped_in = req_chan.query_time;
                     end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = '0;
                        walk_idx_in     = '0;
                        state_in        = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (query_ff >= rd_data.span_end) begin
               end_sum_in   = end_sum_ff + rd_data.span_end;
               start_sum_in = start_sum_ff + rd_data.span_start;
               if (more_entries) begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = walk_idx_ff + IDX_W'(1);
                  walk_idx_in     = walk_idx_ff + IDX_W'(1);
               end else begin
                  state_in = ST_SUM;
               end
            end else begin
               // query lands inside or ahead of this span: stop the walk
               if (query_ff > rd_data.span_start) begin
                  end_sum_in   = end_sum_ff + query_ff;
                  start_sum_in = start_sum_ff + rd_data.span_start;
               end
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            res_mapped_in = query_ff - end_sum_ff + start_sum_ff;
            state_in      = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_mapped_in = res_mapped_ff;
               out_status_in = res_status_ff;
               out_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_acc_ff  <= TIME_MIN;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_acc_ff  <= last_acc_in;
         out_valid_ff <= out_valid_in;
      end
      last_start_ff <= last_start_in;
      last_end_ff   <= last_end_in;
      query_ff      <= query_in;
      end_sum_ff    <= end_sum_in;
      start_sum_ff  <= start_sum_in;
      walk_idx_ff   <= walk_idx_in;
      res_mapped_ff <= res_mapped_in;
      res_status_ff <= res_status_in;
      out_mapped_ff <= out_mapped_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.mapped_time = out_mapped_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.entry_count = out_count_ff;

   `CLMTR_ASSERT(a_no_write_in_walk, clock, reset, (state_ff == ST_WALK) |-> !ram_req.wr_en, "table written during a walk")
   `CLMTR_ASSERT(a_walk_has_data, clock, reset, (state_ff == ST_WALK) |-> $past(ram_req.rd_en), "walk step without a read issued")
   `CLMTR_ASSERT(a_read_below_count, clock, reset, ram_req.rd_en |-> (CNT_W'(ram_req.rd_addr) < count_ff), "read beyond held entries")
   `CLMTR_ASSERT(a_count_bound, clock, reset, count_ff <= COUNT_MAX, "entry count above table size")
   `CLMTR_ASSERT_NEXT(a_fin_loads_out, clock, reset, state_ff == ST_FIN && slot_free, out_valid_ff && state_ff == ST_IDLE, "finished result not loaded")

endmodule

>>> test/cut_list_merge_time_remap_checker.sv
`timescale 1ns / 1ps

module cut_list_merge_time_remap_checker import clmtr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   clmtr_req_if        req_chan,
   clmtr_rsp_if        rsp_chan,
   output int unsigned mismatch_count,
   output int unsigned outcome_backlog,
   output int unsigned outcome_checked,
   output int unsigned empty_spans,
   output int unsigned order_drops,
   output int unsigned full_drops
);

   typedef logic signed [TIME_W-1:0] usec_type;
   typedef logic signed [TIME_W:0]   wide_usec_type;

   typedef struct packed {
      usec_type         mapped_time;
      logic [1:0]       status;
      logic [CNT_W-1:0] entry_count;
   } outcome_type;

   // own copy of the merged span table
   usec_type         cut_lo [MAX_SPANS];
   usec_type         cut_hi [MAX_SPANS];
   logic [CNT_W-1:0] span_total;
   usec_type         newest_start;

   outcome_type outcome_q [$];
   int unsigned mismatches;
   int unsigned checked;
   int unsigned n_empty;
   int unsigned n_order;
   int unsigned n_full;

   function automatic logic [1:0] add_cut(input usec_type s, input usec_type e);
      logic [IDX_W-1:0] tail;
      if (e <= s) return STATUS_EMPTY;
      if (s < newest_start) return STATUS_ORDER;
      if (span_total != '0) begin
         tail = IDX_W'(span_total - 1'b1);
         // overlapping or touching spans fold into the last entry
         if (s <= cut_hi[tail]) begin
            if (e > cut_hi[tail]) cut_hi[tail] = e;
            newest_start = s;
            return STATUS_OK;
         end
      end
      if (span_total >= COUNT_MAX) return STATUS_FULL;
      cut_lo[span_total[IDX_W-1:0]] = s;
      cut_hi[span_total[IDX_W-1:0]] = e;
      span_total = span_total + 1'b1;
      newest_start = s;
      return STATUS_OK;
   endfunction

   function automatic usec_type remap_time(input usec_type t);
      wide_usec_type removed;
      bit            done;
      removed = '0;
      done    = 1'b0;
      for (int i = 0; i < MAX_SPANS; i++) begin
         if (!done && i < span_total) begin
            if (t >= cut_hi[i]) begin
               removed = removed + (wide_usec_type'(cut_hi[i]) - wide_usec_type'(cut_lo[i]));
            end else begin
               // query falls inside or before this span, walk stops here
               if (t > cut_lo[i]) begin
                  removed = removed + (wide_usec_type'(t) - wide_usec_type'(cut_lo[i]));
               end
               done = 1'b1;
            end
         end
      end
      return usec_type'(wide_usec_type'(t) - removed);
   endfunction

   function automatic outcome_type predict_outcome(input logic [1:0] act, input usec_type s,
                                                   input usec_type e, input usec_type q);
      outcome_type o;
      o.mapped_time = '0;
      o.status      = STATUS_OK;
      case (act)
         ACTION_CLEAR: begin
            span_total   = '0;
            newest_start = TIME_MIN;
         end
         ACTION_ADD: o.status = add_cut(s, e);
         ACTION_MAP: o.mapped_time = remap_time(q);
         default: ;
      endcase
      o.entry_count = span_total;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         span_total   = '0;
         newest_start = TIME_MIN;
         outcome_q.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (outcome_q.size() == 0) begin
               $error("result with no command outstanding: mapped_time %0d status %0d entry_count %0d",
                      rsp_chan.mapped_time, rsp_chan.status, rsp_chan.entry_count);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_chan.mapped_time !== want.mapped_time) begin
                  $error("mapped_time expected %0d actual %0d", want.mapped_time,
                         rsp_chan.mapped_time);
                  mismatches++;
               end
               if (rsp_chan.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_chan.status);
                  mismatches++;
               end
               if (rsp_chan.entry_count !== want.entry_count) begin
                  $error("entry_count expected %0d actual %0d", want.entry_count,
                         rsp_chan.entry_count);
                  mismatches++;
               end
               checked++;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            want = predict_outcome(req_chan.action, req_chan.span_start, req_chan.span_end,
                                   req_chan.query_time);
            case (want.status)
               STATUS_EMPTY: n_empty++;
               STATUS_ORDER: n_order++;
               STATUS_FULL:  n_full++;
               default: ;
            endcase
            outcome_q.push_back(want);
         end
      end
      mismatch_count  <= mismatches;
      outcome_backlog <= outcome_q.size();
      outcome_checked <= checked;
      empty_spans     <= n_empty;
      order_drops     <= n_order;
      full_drops      <= n_full;
   end

endmodule

>>> test/cut_list_merge_time_remap_top_tb.sv
`timescale 1ns / 1ps

module cut_list_merge_time_remap_top_tb;
   import clmtr_pkg::*;

   localparam logic [1:0] ACTION_SPARE = 2'd3;
   localparam longint USEC_MIN    = -64'sd140737488355328;
   localparam longint USEC_MAX    = 64'sd140737488355327;
   localparam int     CYCLE_LIMIT = 600000;
   localparam int     PHASE_ITEMS = 128;

   logic clock;
   logic reset;

   clmtr_req_if req_chan ();
   clmtr_rsp_if rsp_chan ();

   int unsigned mismatch_count;
   int unsigned outcome_backlog;
   int unsigned outcome_checked;
   int unsigned empty_spans;
   int unsigned order_drops;
   int unsigned full_drops;

   int unsigned cycles;
   int          send_gap_pct;
   int          stall_pct;
   int unsigned sent;
   int unsigned clears_sent;
   int unsigned adds_sent;
   int unsigned maps_sent;
   int unsigned spares_sent;

   // shape of the table as the stimulus sees it, used to keep spans in order and to aim map probes
   longint tail_lo;
   longint tail_hi;
   bit     table_fresh;

   cut_list_merge_time_remap_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cut_list_merge_time_remap_checker span_table_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .mismatch_count  (mismatch_count),
      .outcome_backlog (outcome_backlog),
      .outcome_checked (outcome_checked),
      .empty_spans     (empty_spans),
      .order_drops     (order_drops),
      .full_drops      (full_drops)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d results outstanding", cycles,
                  outcome_backlog);
         $display("cut_list_merge_time_remap_top_tb failed");
         $finish;
      end
   end

   function automatic longint rand48();
      logic signed [TIME_W-1:0] r;
      r = TIME_W'({$urandom, $urandom});
      return r;
   endfunction

   // inclusive range, width of the range well below 2**63
   function automatic longint pick_range(input longint lo, input longint hi);
      longint unsigned r;
      r = {$urandom, $urandom};
      return lo + longint'(r % unsigned'(hi - lo + 1));
   endfunction

   function automatic longint step_size();
      return ($urandom_range(9) == 0) ? pick_range(1, 64'sd2147483648) : pick_range(1, 1000);
   endfunction

   task automatic send_command(input logic [1:0] act, input longint s, input longint e,
                               input longint q);
      while ($urandom_range(99) < send_gap_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.span_start <= TIME_W'(s);
      req_chan.span_end   <= TIME_W'(e);
      req_chan.query_time <= TIME_W'(q);
      do @(posedge clock); while (!req_chan.ready);
      sent++;
      case (act)
         ACTION_CLEAR: clears_sent++;
         ACTION_ADD:   adds_sent++;
         ACTION_MAP:   maps_sent++;
         default:      spares_sent++;
      endcase
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outcome_backlog != 0) @(posedge clock);
   endtask

   // one run of spans sorted by start, with map probes and some noise mixed in
   task automatic run_span_sequence(input bit filling);
      longint base;
      longint s;
      longint e;
      longint q;
      int     spans;
      int     kind;
      int     map_pct;
      int     new_pct;
      if (filling || tail_hi > USEC_MAX - (64'sd1 <<< 36) || $urandom_range(9) < 8) begin
         send_command(ACTION_CLEAR, rand48(), rand48(), rand48());
         case ($urandom_range(3))
            0: base = USEC_MIN;
            1: base = pick_range(-1000, 1000);
            default: base = pick_range(USEC_MIN, USEC_MAX - (64'sd1 <<< 40));
         endcase
         tail_lo     = base;
         tail_hi     = base;
         table_fresh = 1'b1;
      end else begin
         base = tail_lo;
      end
      spans   = filling ? $urandom_range(72, 80) : $urandom_range(1, 8);
      map_pct = filling ? 12 : 40;
      new_pct = filling ? 95 : 45;
      repeat (spans) begin
         kind = $urandom_range(99);
         if (table_fresh || kind < new_pct) begin
            s = table_fresh ? tail_hi : tail_hi + step_size();
            e = s + step_size();
         end else begin
            case (kind % 5)
               0: begin
                  s = tail_hi;
                  e = s + step_size();
               end
               1: begin
                  s = pick_range(tail_lo, tail_hi);
                  e = pick_range(s + 1, tail_hi + 1000);
               end
               2: begin
                  s = tail_hi + step_size();
                  e = s - pick_range(0, 3);
               end
               3: begin
                  s = tail_lo - pick_range(1, 1000);
                  if (s < USEC_MIN) s = USEC_MIN;
                  e = s + step_size();
               end
               default: begin
                  s = rand48();
                  e = rand48();
               end
            endcase
         end
         if (!table_fresh && kind >= new_pct && kind % 5 == 4) begin
            send_command(2'($urandom_range(3)), s, e, rand48());
         end else begin
            send_command(ACTION_ADD, s, e, rand48());
            if (e > s && s >= tail_lo) begin
               tail_lo     = s;
               table_fresh = 1'b0;
               if (e > tail_hi) tail_hi = e;
            end
         end
         if ($urandom_range(99) < map_pct) begin
            case ($urandom_range(4))
               0: q = tail_lo;
               1: q = tail_hi;
               2: q = rand48();
               default: q = pick_range(base - 2000, tail_hi + 2000);
            endcase
            if (q < USEC_MIN) q = USEC_MIN;
            if (q > USEC_MAX) q = USEC_MAX;
            send_command(ACTION_MAP, rand48(), rand48(), q);
         end
      end
   endtask

   initial begin
      int unsigned target;
      reset               = 1'b1;
      cycles              = 0;
      send_gap_pct        = 0;
      stall_pct           = 0;
      req_chan.valid      = 1'b0;
      req_chan.action     = ACTION_CLEAR;
      req_chan.span_start = '0;
      req_chan.span_end   = '0;
      req_chan.query_time = '0;
      rsp_chan.ready      = 1'b0;
      tail_lo             = USEC_MIN;
      tail_hi             = USEC_MIN;
      table_fresh         = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, boundary spans, merge and drop cases, spare code
      send_command(ACTION_MAP, rand48(), rand48(), USEC_MIN);
      send_command(ACTION_MAP, rand48(), rand48(), USEC_MAX);
      send_command(ACTION_ADD, 5, 5, rand48());
      send_command(ACTION_ADD, 9, 3, rand48());
      send_command(ACTION_ADD, USEC_MIN, USEC_MIN + 10, rand48());
      send_command(ACTION_ADD, USEC_MIN + 10, USEC_MIN + 20, rand48());
      send_command(ACTION_ADD, USEC_MIN + 12, USEC_MIN + 15, rand48());
      send_command(ACTION_ADD, USEC_MIN + 5, USEC_MIN + 40, rand48());
      send_command(ACTION_ADD, USEC_MIN + 10, USEC_MIN + 30, rand48());
      send_command(ACTION_ADD, -100, 0, rand48());
      send_command(ACTION_ADD, 200, 300, rand48());
      send_command(ACTION_MAP, rand48(), rand48(), USEC_MIN);
      send_command(ACTION_MAP, rand48(), rand48(), USEC_MIN + 25);
      send_command(ACTION_MAP, rand48(), rand48(), -100);
      send_command(ACTION_MAP, rand48(), rand48(), -50);
      send_command(ACTION_MAP, rand48(), rand48(), 0);
      send_command(ACTION_MAP, rand48(), rand48(), 250);
      send_command(ACTION_ADD, USEC_MAX - 5, USEC_MAX, rand48());
      send_command(ACTION_MAP, rand48(), rand48(), USEC_MAX - 1);
      send_command(ACTION_MAP, rand48(), rand48(), USEC_MAX);
      send_command(ACTION_SPARE, rand48(), rand48(), rand48());
      send_command(ACTION_CLEAR, rand48(), rand48(), rand48());
      send_command(ACTION_MAP, rand48(), rand48(), 7);
      send_command(ACTION_ADD, USEC_MIN, USEC_MAX, rand48());
      send_command(ACTION_MAP, rand48(), rand48(), USEC_MAX);

      for (int ph = 0; ph < 4; ph++) begin
         // sender holds off until the block has returned everything
         wait_drained();
         case (ph)
            0: begin
               send_gap_pct = 0;
               stall_pct    = 0;
            end
            1: begin
               send_gap_pct = 54;
               stall_pct    = 0;
            end
            2: begin
               send_gap_pct = 0;
               stall_pct    = 54;
            end
            default: begin
               send_gap_pct = 22;
               stall_pct    = 22;
            end
         endcase
         target = sent + PHASE_ITEMS;
         if (ph == 0 || ph == 3) run_span_sequence(1'b1);
         while (sent < target) run_span_sequence($urandom_range(14) == 0);
      end

      wait_drained();
      repeat (80) @(posedge clock);
      $display("covered %0d commands: %0d clear, %0d add, %0d map, %0d spare code",
               sent, clears_sent, adds_sent, maps_sent, spares_sent);
      $display("%0d results checked; adds empty %0d, out of order %0d, table full %0d",
               outcome_checked, empty_spans, order_drops, full_drops);
      if (mismatch_count == 0 && outcome_backlog == 0) begin
         $display("cut_list_merge_time_remap_top_tb passed");
      end else begin
         $display("cut_list_merge_time_remap_top_tb failed");
      end
      $finish;
   end

endmodule
